@@ design/tgsr_pkg.sv @@
// Shared types, bus constants and the 5x8 font table for the glyph stream renderer.
// No dependencies.
package tgsr_pkg;

  typedef struct packed {
    logic       action;
    logic [6:0] character;
    logic [6:0] column;
    logic [1:0] row;
    logic       first_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [1:0] bus_event;
    logic [7:0] bus_byte;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] column;
    logic [1:0] row;
  } cursor_t;

  localparam int NUM_SLOTS = 18;
  typedef logic [4:0]           slot_t;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // one decoded request, ready for the event sequencer
  typedef struct packed {
    slot_mask_t  mask;
    logic [39:0] glyph;
    logic [6:0]  cmd_x;
    logic [1:0]  cmd_y;
  } job_t;

  localparam logic       ACT_CHAR   = 1'b0;
  localparam logic       ACT_CURSOR = 1'b1;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_WRITE = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  localparam logic [7:0] BUS_ADDR    = 8'h78;
  localparam logic [7:0] CMD_MODE    = 8'h00;
  localparam logic [7:0] DATA_MODE   = 8'h40;
  localparam logic [7:0] LINE_LIMIT  = 8'd122;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CHAR_ADV    = 8'd6;
  localparam logic [6:0] FIRST_GLYPH = 7'd32;

  // event script positions
  localparam slot_t SL_OPEN_START  = 5'd0;
  localparam slot_t SL_OPEN_DATA   = 5'd1;
  localparam slot_t SL_BLANK       = 5'd2;
  localparam slot_t SL_GLYPH0      = 5'd3;
  localparam slot_t SL_GLYPH1      = 5'd4;
  localparam slot_t SL_GLYPH2      = 5'd5;
  localparam slot_t SL_GLYPH3      = 5'd6;
  localparam slot_t SL_GLYPH4      = 5'd7;
  localparam slot_t SL_WRAP_STOP   = 5'd8;
  localparam slot_t SL_CMD_START   = 5'd9;
  localparam slot_t SL_CMD_MODE    = 5'd10;
  localparam slot_t SL_CMD_COL_LO  = 5'd11;
  localparam slot_t SL_CMD_COL_HI  = 5'd12;
  localparam slot_t SL_CMD_PAGE    = 5'd13;
  localparam slot_t SL_CMD_STOP    = 5'd14;
  localparam slot_t SL_REOPEN_STRT = 5'd15;
  localparam slot_t SL_REOPEN_DATA = 5'd16;
  localparam slot_t SL_LAST_STOP   = 5'd17;

  // five glyph columns, leftmost in the top byte; indexes past the font are blank
  function automatic logic [39:0] glyph_row(input logic [6:0] idx);
    logic [39:0] r;
    case (idx)
      7'd0:  r = 40'h0000000000;  7'd1:  r = 40'h00005F0000;
      7'd2:  r = 40'h0007000700;  7'd3:  r = 40'h147F147F14;
      7'd4:  r = 40'h242A7F2A12;  7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649552250;  7'd7:  r = 40'h0004030000;
      7'd8:  r = 40'h001C224100;  7'd9:  r = 40'h0041221C00;
      7'd10: r = 40'h14083E0814;  7'd11: r = 40'h08083E0808;
      7'd12: r = 40'h0080600000;  7'd13: r = 40'h0808080808;
      7'd14: r = 40'h0060600000;  7'd15: r = 40'h2010080402;
      7'd16: r = 40'h3E5149453E;  7'd17: r = 40'h44427F4040;
      7'd18: r = 40'h4261514946;  7'd19: r = 40'h2241494936;
      7'd20: r = 40'h1814127F10;  7'd21: r = 40'h2F49494931;
      7'd22: r = 40'h3E49494932;  7'd23: r = 40'h0301710907;
      7'd24: r = 40'h3649494936;  7'd25: r = 40'h264949493E;
      7'd26: r = 40'h0036360000;  7'd27: r = 40'h0080680000;
      7'd28: r = 40'h0008142200;  7'd29: r = 40'h1414141414;
      7'd30: r = 40'h0022140800;  7'd31: r = 40'h0201510906;
      7'd32: r = 40'h3E415D555E;  7'd33: r = 40'h7C1211127C;
      7'd34: r = 40'h7F49494936;  7'd35: r = 40'h3E41414122;
      7'd36: r = 40'h7F4141221C;  7'd37: r = 40'h7F49494941;
      7'd38: r = 40'h7F09090901;  7'd39: r = 40'h3E4149493A;
      7'd40: r = 40'h7F0808087F;  7'd41: r = 40'h41417F4141;
      7'd42: r = 40'h2040413F01;  7'd43: r = 40'h7F08142241;
      7'd44: r = 40'h7F40404040;  7'd45: r = 40'h7F020C027F;
      7'd46: r = 40'h7F0408107F;  7'd47: r = 40'h3E4141413E;
      7'd48: r = 40'h7F09090906;  7'd49: r = 40'h3E4141C1BE;
      7'd50: r = 40'h7F09192946;  7'd51: r = 40'h2649494932;
      7'd52: r = 40'h01017F0101;  7'd53: r = 40'h3F4040403F;
      7'd54: r = 40'h1F2040201F;  7'd55: r = 40'h3F4038403F;
      7'd56: r = 40'h6314081463;  7'd57: r = 40'h0708700807;
      7'd58: r = 40'h6151494543;  7'd59: r = 40'h007F414100;
      7'd60: r = 40'h0204081020;  7'd61: r = 40'h0041417F00;
      7'd62: r = 40'h0804020408;  7'd63: r = 40'h4040404040;
      7'd64: r = 40'h0000030400;  7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7F44444438;  7'd67: r = 40'h3844444428;
      7'd68: r = 40'h384444447F;  7'd69: r = 40'h3854545418;
      7'd70: r = 40'h08FE090102;  7'd71: r = 40'h18A4A4A478;
      7'd72: r = 40'h7F04040478;  7'd73: r = 40'h00447D4000;
      7'd74: r = 40'h0080847D00;  7'd75: r = 40'h417F102844;
      7'd76: r = 40'h00417F4000;  7'd77: r = 40'h7C047C0478;
      7'd78: r = 40'h7C04040478;  7'd79: r = 40'h3844444438;
      7'd80: r = 40'hFC24242418;  7'd81: r = 40'h18242424FC;
      7'd82: r = 40'h7C08040408;  7'd83: r = 40'h0854545420;
      7'd84: r = 40'h043F444020;  7'd85: r = 40'h3C4040403C;
      7'd86: r = 40'h1C2040201C;  7'd87: r = 40'h3C4030403C;
      7'd88: r = 40'h4428102844;  7'd89: r = 40'h1CA0A0A07C;
      7'd90: r = 40'h4464544C44;  7'd91: r = 40'h0808364141;
      7'd92: r = 40'h0000FF0000;  7'd93: r = 40'h4141360808;
      7'd94: r = 40'h0804081008;  7'd95: r = 40'hFFFFFFFFFF;
      default: r = 40'h0000000000;
    endcase
    return r;
  endfunction

endpackage

@@ design/tgsr_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module tgsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/tgsr_cursor.sv @@
// Decode stage: reads the cursor from its RAM, updates it and builds the event job.
// Depends on tgsr_pkg and tgsr_ram.
module tgsr_cursor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tgsr_pkg::in_item_t in_data,
  output logic               job_valid,
  output tgsr_pkg::job_t     job,
  input  logic               job_take
);
  import tgsr_pkg::*;

  localparam int CUR_W = $bits(cursor_t);

  logic       dec_valid_r;
  in_item_t   dec_r;
  logic       cur_vld_r;
  logic       byp_r;
  logic       zero_r;
  cursor_t    byp_data_r;
  logic       accept;
  logic       dec_take;
  cursor_t    ram_rdata;
  cursor_t    cur;
  cursor_t    wr_data;
  logic [7:0] sum;
  logic       wrap;

  assign in_stall = dec_valid_r && !job_take;
  assign accept   = in_valid && !in_stall;
  assign dec_take = dec_valid_r && job_take;

  tgsr_ram #(.WIDTH(CUR_W), .DEPTH(2)) u_cur_ram (
    .clk    (clk),
    .wr_en  (dec_take),
    .wr_addr(1'b0),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(1'b0),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
      cur_vld_r   <= 1'b0;
      byp_r       <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      if (accept) begin
        dec_valid_r <= 1'b1;
        // the request ahead may write the cursor in the same cycle as this read
        byp_r       <= dec_take;
        zero_r      <= !cur_vld_r && !dec_take;
      end else if (dec_take) begin
        dec_valid_r <= 1'b0;
      end
      if (dec_take) begin
        cur_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r      <= in_data;
      byp_data_r <= wr_data;
    end
  end

  always_comb begin
    if (byp_r) begin
      cur = byp_data_r;
    end else if (zero_r) begin
      cur = '0;
    end else begin
      cur = ram_rdata;
    end
    sum  = cur.column + CHAR_ADV;
    wrap = (dec_r.action == ACT_CHAR) && (sum > LINE_LIMIT);

    if (dec_r.action == ACT_CURSOR) begin
      wr_data.column = {1'b0, dec_r.column};
      wr_data.row    = dec_r.row;
      job.mask       = slot_mask_t'(18'b000111111000000000);
      job.cmd_x      = dec_r.column;
      job.cmd_y      = dec_r.row;
    end else begin
      if (wrap) begin
        wr_data.column = '0;
        wr_data.row    = cur.row + 2'd1;
      end else begin
        wr_data.column = sum;
        wr_data.row    = cur.row;
      end
      job.mask  = {dec_r.last_char, {9{wrap}}, 6'b111111, {2{dec_r.first_char}}};
      job.cmd_x = '0;
      job.cmd_y = cur.row + 2'd1;
    end
    job.glyph = glyph_row(dec_r.character - FIRST_GLYPH);
  end

  assign job_valid = dec_valid_r;

  // column stays on screen after every update
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_take |-> !wr_data.column[7])
    else $error("cursor column written past 127");

  a_wrap_home: assert property (@(posedge clk) disable iff (!rst_n)
    dec_take && job.mask[SL_WRAP_STOP] |-> wr_data.column == 8'd0)
    else $error("line wrap did not home the cursor");

  a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid_r && !job_take |=> dec_valid_r && $stable(dec_r))
    else $error("decode request lost while the sequencer was busy");

endmodule

@@ design/tgsr_emit.sv @@
// Event sequencer: walks the job's slot mask and drives the output register.
// Depends on tgsr_pkg.
module tgsr_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  tgsr_pkg::job_t      job,
  output logic                job_take,
  output logic                out_valid,
  input  logic                out_stall,
  output tgsr_pkg::out_item_t out_data
);
  import tgsr_pkg::*;

  job_t      job_r;
  logic      job_valid_r;
  logic      out_valid_r;
  slot_t     slot_r;
  slot_t     slot_nxt;
  slot_t     first_slot;
  logic      has_next;
  logic      adv;
  logic      load;
  out_item_t out_r;
  out_item_t ev;

  assign adv      = job_valid_r && (!out_valid_r || !out_stall);
  assign job_take = !job_valid_r || (adv && !has_next);
  assign load     = job_valid && job_take;

  always_comb begin
    slot_nxt   = slot_r;
    has_next   = 1'b0;
    first_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (job_r.mask[i] && (slot_t'(i) > slot_r)) begin
        slot_nxt = slot_t'(i);
        has_next = 1'b1;
      end
      if (job.mask[i]) begin
        first_slot = slot_t'(i);
      end
    end
  end

  always_comb begin
    ev.bus_event = EV_WRITE;
    ev.bus_byte  = 8'h00;
    ev.run_end   = !has_next;
    case (slot_r)
      SL_OPEN_START, SL_CMD_START, SL_REOPEN_STRT: begin
        ev.bus_event = EV_START;
        ev.bus_byte  = BUS_ADDR;
      end
      SL_OPEN_DATA, SL_REOPEN_DATA: ev.bus_byte = DATA_MODE;
      SL_BLANK:      ev.bus_byte = 8'h00;
      SL_GLYPH0:     ev.bus_byte = job_r.glyph[39:32];
      SL_GLYPH1:     ev.bus_byte = job_r.glyph[31:24];
      SL_GLYPH2:     ev.bus_byte = job_r.glyph[23:16];
      SL_GLYPH3:     ev.bus_byte = job_r.glyph[15:8];
      SL_GLYPH4:     ev.bus_byte = job_r.glyph[7:0];
      SL_WRAP_STOP, SL_CMD_STOP, SL_LAST_STOP: begin
        ev.bus_event = EV_STOP;
        ev.bus_byte  = 8'h00;
      end
      SL_CMD_MODE:   ev.bus_byte = CMD_MODE;
      SL_CMD_COL_LO: ev.bus_byte = {4'b0000, job_r.cmd_x[3:0]};
      SL_CMD_COL_HI: ev.bus_byte = CMD_COL_HI | {5'b00000, job_r.cmd_x[6:4]};
      SL_CMD_PAGE:   ev.bus_byte = CMD_PAGE | {6'b000000, job_r.cmd_y};
      default:       ev.bus_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
      end else if (adv && !has_next) begin
        job_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r  <= job;
      slot_r <= first_slot;
    end else if (adv) begin
      slot_r <= slot_nxt;
    end
    if (adv) begin
      out_r <= ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_slot_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> job_r.mask[slot_r])
    else $error("sequencer sits on a disabled slot");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.run_end |-> job_valid_r)
    else $error("request ended without a final event");

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !has_next |=> out_valid_r && out_r.run_end)
    else $error("last event of a request not marked");

endmodule

@@ design/text_glyph_stream_renderer_core.sv @@
// Top level of the text glyph stream renderer.
// Depends on tgsr_pkg, tgsr_cursor, tgsr_emit.
//
// Turns character and set-cursor requests into start / write / stop events for a
// 128x32 monochrome display controller. The cursor lives in a small RAM read at
// accept and written back in the decode stage, with a bypass for back-to-back
// requests. The sequencer emits one event per cycle while out_stall is low.
// A set-cursor request has 6 events; a character has 6, plus 2 when it opens
// a string, 1 when it closes one and 9 when it wraps the line (6 to 18 events).
// The next request is decoded while the current one is emitted; the first
// event passes the decode register, the job register and the output register.
module text_glyph_stream_renderer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tgsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tgsr_pkg::out_item_t out_data
);
  import tgsr_pkg::*;

  logic job_valid;
  logic job_take;
  job_t job;

  tgsr_cursor u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take)
  );

  tgsr_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
